>>> rtl/sdaf_pkg.sv
// Package for the signed decimal ASCII formatter.
// Payload structs, queue entry type and shared constants; no dependencies.
`default_nettype none

package sdaf_pkg;

  localparam int MAX_DIGITS_DEF  = 10;
  localparam int VALUE_WIDTH_DEF = 32;
  localparam int MAG_W           = 32;  // widest supported value
  localparam int QUEUE_DEPTH     = 2;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_MINUS = 8'h2D;

  typedef struct packed {
    logic signed [31:0] value;
    logic [3:0]         digit_count;
  } in_item_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       last_char;
  } out_item_t;

  // Classified transaction handed from the front to the back.
  typedef struct packed {
    logic [MAG_W-1:0] mag;
    logic [3:0]       ndig;   // already saturated
    logic             neg;
    logic             zero;
  } cmd_t;

endpackage

`default_nettype wire

>>> rtl/sdaf_front.sv
// Front end: accepts input transactions and classifies them (sign, zero,
// magnitude, saturated digit count). Depends on sdaf_pkg.
`default_nettype none

module sdaf_front import sdaf_pkg::*; #(
  parameter int MAX_DIGITS  = MAX_DIGITS_DEF,
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire in_item_t in_data,
  input  wire logic     q_full,
  output logic          q_push,
  output cmd_t          q_cmd
);

  logic [VALUE_WIDTH-1:0] raw;
  logic [VALUE_WIDTH-1:0] mag;
  logic                   neg;

  assign raw = in_data.value[VALUE_WIDTH-1:0];
  assign neg = raw[VALUE_WIDTH-1];
  // most negative value wraps to 2^(W-1), read as unsigned
  assign mag = neg ? (~raw + VALUE_WIDTH'(1)) : raw;

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_cmd.mag  = MAG_W'(mag);
    q_cmd.neg  = neg;
    q_cmd.zero = (raw == '0);
    q_cmd.ndig = (in_data.digit_count > 4'(MAX_DIGITS)) ? 4'(MAX_DIGITS)
                                                        : in_data.digit_count;
  end

endmodule

`default_nettype wire

>>> rtl/sdaf_queue.sv
// Two-entry queue of classified transactions between front and back.
// Depends on sdaf_pkg.
`default_nettype none

module sdaf_queue import sdaf_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire cmd_t wr_data,
  input  wire logic pop,
  output cmd_t      rd_data,
  output logic      full,
  output logic      empty
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  cmd_t          mem [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full    = (count == CW'(QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && full && !pop))
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !(pop && empty))
    else $error("queue pop while empty");

endmodule

`default_nettype wire

>>> rtl/sdaf_back.sv
// Back end: binary to BCD by double dabble (one shift per cycle), then
// emits sign and digits through an output register. Depends on sdaf_pkg.
`default_nettype none

module sdaf_back import sdaf_pkg::*; #(
  parameter int MAX_DIGITS  = MAX_DIGITS_DEF,
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic q_empty,
  input  wire cmd_t q_data,
  output logic      q_pop,
  output logic      out_valid,
  input  wire logic out_ready,
  output out_item_t out_data
);

  localparam int SW  = $clog2(VALUE_WIDTH + 1);
  localparam int DCW = $clog2(MAX_DIGITS + 1);
  localparam int IW  = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam int BW  = 4 * MAX_DIGITS;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_CONV = 3'b010,
    S_EMIT = 3'b100
  } state_t;

  state_t                        state;
  logic [VALUE_WIDTH-1:0]        bin;
  logic [MAX_DIGITS-1:0][3:0]    bcd;
  logic [MAX_DIGITS-1:0][3:0]    bcd_adj;
  logic [BW-1:0]                 bcd_next;
  logic [SW-1:0]                 shift_cnt;
  logic [DCW-1:0]                dig_left;
  logic [IW-1:0]                 dig_idx;
  logic                          neg;
  logic                          zero;
  logic                          sign_pend;

  logic                          out_free;
  logic                          emit;
  logic                          emit_last;
  logic [7:0]                    emit_char;
  logic                          fire;
  logic                          finish;

  // add-3 correction on every digit, then shift in the next binary bit;
  // the carry out of the top digit is dropped
  always_comb begin
    for (int i = 0; i < MAX_DIGITS; i++) begin
      bcd_adj[i] = (bcd[i] >= 4'd5) ? bcd[i] + 4'd3 : bcd[i];
    end
    bcd_next = BW'({bcd_adj, bin[VALUE_WIDTH-1]});
  end

  assign dig_idx  = IW'(dig_left - DCW'(1));
  assign out_free = !out_valid || out_ready;
  assign q_pop    = (state == S_IDLE) && !q_empty;

  always_comb begin
    emit      = 1'b0;
    emit_last = 1'b0;
    emit_char = CH_ZERO;
    if (zero) begin
      emit      = 1'b1;
      emit_last = 1'b1;
    end else if (sign_pend) begin
      emit      = 1'b1;
      emit_char = CH_MINUS;
      emit_last = (dig_left == '0);
    end else if (dig_left != '0) begin
      emit      = 1'b1;
      emit_char = CH_ZERO + {4'd0, bcd[dig_idx]};
      emit_last = (dig_left == DCW'(1));
    end
  end

  assign fire   = (state == S_EMIT) && emit && out_free;
  // positive value with no digits finishes without a character
  assign finish = (state == S_EMIT) && ((fire && emit_last) || !emit);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      sign_pend <= 1'b0;
      zero      <= 1'b0;
      dig_left  <= '0;
      shift_cnt <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (!q_empty) begin
            zero      <= q_data.zero;
            sign_pend <= q_data.neg && !q_data.zero;
            dig_left  <= DCW'(q_data.ndig);
            shift_cnt <= SW'(VALUE_WIDTH);
            state     <= q_data.zero ? S_EMIT : S_CONV;
          end
        end
        S_CONV: begin
          shift_cnt <= shift_cnt - SW'(1);
          if (shift_cnt == SW'(1)) begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (fire) begin
            if (zero) begin
              zero <= 1'b0;
            end else if (sign_pend) begin
              sign_pend <= 1'b0;
            end else begin
              dig_left <= dig_left - DCW'(1);
            end
          end
          if (finish) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk) begin
    if (state == S_IDLE && !q_empty) begin
      bin <= q_data.mag[VALUE_WIDTH-1:0];
      bcd <= '0;
      neg <= q_data.neg;
    end else if (state == S_CONV) begin
      bin <= {bin[VALUE_WIDTH-2:0], 1'b0};
      bcd <= bcd_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data.char_code <= emit_char;
      out_data.last_char <= emit_last;
    end
  end

  a_pop_only_idle: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> (state == S_IDLE) && !q_empty)
    else $error("dequeue outside idle");

  a_minus_only_neg: assert property (@(posedge clk) disable iff (rst)
    fire && (emit_char == CH_MINUS) |-> neg)
    else $error("minus sign on a non-negative value");

  a_char_legal: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.char_code == CH_MINUS) ||
                  ((out_data.char_code >= CH_ZERO) &&
                   (out_data.char_code <= CH_ZERO + 8'd9)))
    else $error("illegal character code");

  a_conv_enters_emit: assert property (@(posedge clk) disable iff (rst)
    (state == S_CONV) && (shift_cnt == SW'(1)) |=> (state == S_EMIT))
    else $error("conversion did not hand over to emit");

endmodule

`default_nettype wire

>>> rtl/signed_decimal_ascii_formatter_top.sv
// Top level of the signed decimal ASCII formatter.
// Instantiates sdaf_front, sdaf_queue and sdaf_back; depends on sdaf_pkg.
//
//  channel  | direction | handshake             | payload
//  ---------+-----------+-----------------------+--------------------------------
//  in       | input     | in_valid / in_ready   | in_data  (value, digit_count)
//  out      | output    | out_valid / out_ready | out_data (char_code, last_char)
//
// An item is dequeued, shifted through VALUE_WIDTH bits (skipped for zero), then
// emitted character by character through the output register; the double dabble
// register shifts one binary bit per cycle.
// Reset clears control state only; there is no clearing pass.
// A two-entry queue lets the input side keep accepting while the back end converts
// until it is full; a held output register stalls the back end, and in turn the input.
`default_nettype none

module signed_decimal_ascii_formatter_top import sdaf_pkg::*; #(
  parameter int MAX_DIGITS  = MAX_DIGITS_DEF,
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_data
);

  logic q_push;
  logic q_pop;
  logic q_full;
  logic q_empty;
  cmd_t q_wr;
  cmd_t q_rd;

  sdaf_front #(
    .MAX_DIGITS  (MAX_DIGITS),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_front (
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cmd    (q_wr)
  );

  sdaf_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .wr_data (q_wr),
    .pop     (q_pop),
    .rd_data (q_rd),
    .full    (q_full),
    .empty   (q_empty)
  );

  sdaf_back #(
    .MAX_DIGITS  (MAX_DIGITS),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_data    (q_rd),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
